// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SMTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SMTC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/smtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtc_pkg
// Codes and types shared by the sync marker time calibration core.
// ----------------------------------------------------------------------------
package smtc_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_CONVERT = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_INTERP = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_ENDS   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOSYNC = 2'd1,
    STAT_SLOPE  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  localparam logic [1:0] MODE_RESET = MODE_INTERP;

  // multiply/divide unit status
  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

// ===== rtl/smtc_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtc_muldiv
// Serial (a*b)/d: shift-add multiply then restoring divide, one bit a cycle.
// Quotient must fit TW bits (a < d). Result held until the next start.
// ----------------------------------------------------------------------------
module smtc_muldiv #(
  parameter int unsigned TW = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TW-1:0]          mplier_i,
  input  logic [TW-1:0]          mcand_i,
  input  logic [TW-1:0]          divisor_i,
  output smtc_pkg::md_stat_t     stat_o,
  output logic [TW-1:0]          quot_o,
  output logic [TW-1:0]          rem_o
);
  import smtc_pkg::*;

  localparam int unsigned SW = $clog2(TW + 1);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [SW-1:0]   step_q, step_d;
  logic            done_q, done_d;
  logic [2*TW-1:0] p_q, p_d;
  logic [TW-1:0]   b_q, d_q;

  logic [TW:0]     mul_sum;
  logic [TW:0]     trial;
  logic [TW:0]     trial_diff;
  logic            trial_ge;
  logic            last_step;

  assign mul_sum    = {1'b0, p_q[2*TW-1:TW]} + (p_q[0] ? {1'b0, b_q} : {(TW+1){1'b0}});
  assign trial      = {p_q[2*TW-1:TW], p_q[TW-1]};
  assign trial_ge   = trial >= {1'b0, d_q};
  assign trial_diff = trial - {1'b0, d_q};
  assign last_step  = step_q == SW'(TW - 1);

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    done_d  = 1'b0;
    p_d     = p_q;
    unique case (phase_q)
      PH_MUL: begin
        p_d    = {mul_sum, p_q[TW-1:1]};
        step_d = step_q + SW'(1);
        if (last_step) begin
          phase_d = PH_DIV;
          step_d  = '0;
        end
      end
      PH_DIV: begin
        p_d    = {(trial_ge ? trial_diff[TW-1:0] : trial[TW-1:0]), p_q[TW-2:0], trial_ge};
        step_d = step_q + SW'(1);
        if (last_step) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        if (start_i) begin
          phase_d = PH_MUL;
          step_d  = '0;
          p_d     = {{TW{1'b0}}, mplier_i};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (start_i && phase_q == PH_IDLE) begin
      b_q <= mcand_i;
      d_q <= divisor_i;
    end
  end

  assign stat_o.busy = phase_q != PH_IDLE;
  assign stat_o.done = done_q;
  assign quot_o      = p_q[TW-1:0];
  assign rem_o       = p_q[2*TW-1:TW];

endmodule

// ===== rtl/sync_marker_time_calibration_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_marker_time_calibration_core
// Sync marker table with local-to-global time conversion.
// ----------------------------------------------------------------------------
//  Port group   Dir  Handshake           Moves
//  in_*         in   in_valid/in_ready   one item: append, clear, convert, nop
//  out_*        out  out_valid/out_ready one result item per input item
//  APB          in   psel/penable/pwrite sync_mode register, paddr not decoded
//
//  Append, clear and pass-through go straight to the output step, as does a
//  convert with no syncs. Interpolation tests the hint pair, scans the table
//  on a miss, checks the slope, then runs the serial multiply/divide unit.
//  Right mode tests the hint pair and scans; a miss ends in the end-sync shift.
//  The single table read port paces the scan; the muldiv unit paces the rest.
//  Reset clears the count and sets the mode to interpolate; the table itself is not cleared.
//  A new item is taken as soon as the core is idle, even while the previous
//  result waits on out_ready.
// ----------------------------------------------------------------------------
module sync_marker_time_calibration_core #(
  parameter int unsigned SYNC_DEPTH = 64,
  parameter int unsigned TIME_WIDTH = 48,
  localparam int unsigned IW = $clog2(SYNC_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic signed [TIME_WIDTH-1:0] local_time_i,
  input  logic signed [TIME_WIDTH-1:0] sync_global_time_i,
  input  logic [IW-1:0]                hint_index_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [TIME_WIDTH-1:0] global_time_o,
  output logic [IW-1:0]                sync_index_o,
  output logic [1:0]                   status_o
);
  import smtc_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned AW = (SYNC_DEPTH > 1) ? $clog2(SYNC_DEPTH) : 1;

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_HA    = 4'd1;  // read first entry of hint pair
  localparam logic [3:0] ST_HB    = 4'd2;  // read second entry of hint pair
  localparam logic [3:0] ST_HC    = 4'd3;  // test hint pair
  localparam logic [3:0] ST_SCAN  = 4'd4;  // streaming table scan
  localparam logic [3:0] ST_SLOPE = 4'd5;  // slope window check
  localparam logic [3:0] ST_MD    = 4'd6;  // wait on multiply/divide
  localparam logic [3:0] ST_RND   = 4'd7;  // round and offset
  localparam logic [3:0] ST_EA    = 4'd8;  // read first sync
  localparam logic [3:0] ST_EB    = 4'd9;  // read last sync
  localparam logic [3:0] ST_EC    = 4'd10; // end-sync shift
  localparam logic [3:0] ST_PUT   = 4'd11; // hand result to output register

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [1:0] sync_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_mode_q <= MODE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      sync_mode_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {30'd0, sync_mode_q};

  // --------------------------------------------------------------------------
  // State and registers
  // --------------------------------------------------------------------------
  logic [3:0]           state_q;
  logic [IW-1:0]        cnt_q;
  logic signed [TW-1:0] t_q;
  logic [IW-1:0]        hint_q;
  logic                 use_hint_q;
  logic [2*TW-1:0]      prev_q;
  logic [2*TW-1:0]      rd_data_q;
  logic [IW-1:0]        scan_k_q;
  logic [IW-1:0]        rd_k_q;
  logic                 rd_vld_q;
  logic [TW-1:0]        dl_q, d1_q, mag_q;
  logic                 neg_q;
  logic [TW-1:0]        g1_q;
  logic [TW-1:0]        res_g_q;
  logic [IW-1:0]        res_idx_q;
  logic [1:0]           res_st_q;
  logic                 out_valid_q;
  logic [TW-1:0]        out_g_q;
  logic [IW-1:0]        out_idx_q;
  logic [1:0]           out_st_q;

  logic                 in_acc;
  logic [IW-1:0]        cnt_m1;
  logic                 table_full;
  logic                 mem_we;
  logic [AW-1:0]        rd_addr;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cnt_m1     = cnt_q - IW'(1);
  assign table_full = cnt_q == IW'(SYNC_DEPTH);
  assign mem_we     = in_acc && action_e'(action_i) == ACT_APPEND && !table_full;

  // --------------------------------------------------------------------------
  // Sync table: {global, local} per entry, one write and one read port
  // --------------------------------------------------------------------------
  logic [2*TW-1:0] sync_mem [SYNC_DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sync_mem[cnt_q[AW-1:0]] <= {sync_global_time_i, local_time_i};
    end
    rd_data_q <= sync_mem[rd_addr];
  end

  always_comb begin
    unique case (state_q)
      ST_HA:   rd_addr = (hint_q == '0) ? '0 : cnt_sub(hint_q);
      ST_HB:   rd_addr = hint_q[AW-1:0];
      ST_SCAN: rd_addr = scan_k_q[AW-1:0];
      ST_EB:   rd_addr = cnt_m1[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  function automatic logic [AW-1:0] cnt_sub(input logic [IW-1:0] v);
    logic [IW-1:0] m;
    m = v - IW'(1);
    return m[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Entry test: prev_q holds entry k-1, rd_data_q holds entry k
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] cur_l, cur_g, prv_l, prv_g;
  logic [IW-1:0]        ev_k;
  logic                 hit_interp, hit_right, ev_hit, ev_skip;

  assign cur_l = rd_data_q[TW-1:0];
  assign cur_g = rd_data_q[2*TW-1:TW];
  assign prv_l = prev_q[TW-1:0];
  assign prv_g = prev_q[2*TW-1:TW];
  assign ev_k  = (state_q == ST_HC) ? hint_q : rd_k_q;

  assign hit_interp = (t_q >= prv_l) && (cur_l > t_q);
  assign hit_right  = (cur_l >= t_q) && ((ev_k == '0) || (t_q > prv_l));
  assign ev_hit     = (sync_mode_q == MODE_INTERP) ? hit_interp : hit_right;
  // in interpolate mode entry 0 opens no segment, and the hint was tried already
  assign ev_skip    = (sync_mode_q == MODE_INTERP) &&
                      ((rd_k_q == '0) || (use_hint_q && rd_k_q == hint_q));

  // segment values for interpolation
  logic signed [TW:0] seg_dl, seg_d1, seg_dg;
  logic [TW:0]        seg_mag;
  assign seg_dl  = {cur_l[TW-1], cur_l} - {prv_l[TW-1], prv_l};
  assign seg_d1  = {t_q[TW-1], t_q} - {prv_l[TW-1], prv_l};
  assign seg_dg  = {cur_g[TW-1], cur_g} - {prv_g[TW-1], prv_g};
  assign seg_mag = seg_dg[TW] ? -seg_dg : seg_dg;

  // right-side offset
  logic [TW-1:0] right_g;
  assign right_g = cur_g - cur_l + t_q;

  // slope window 0.9 .. 1.1: 9*dl <= 10*dg <= 11*dl
  logic [TW+3:0] mag_x10, dl_x9, dl_x11;
  logic          slope_bad;
  assign mag_x10   = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1);
  assign dl_x9     = ({4'd0, dl_q} << 3) + {4'd0, dl_q};
  assign dl_x11    = ({4'd0, dl_q} << 3) + ({4'd0, dl_q} << 1) + {4'd0, dl_q};
  assign slope_bad = neg_q || (mag_q == '0) || (mag_x10 < dl_x9) || (mag_x10 > dl_x11);

  // end-sync shift: prev_q holds the first sync, rd_data_q the last
  logic signed [TW:0] da_s, db_s;
  logic [TW:0]        da, db;
  assign da_s = {t_q[TW-1], t_q} - {prv_l[TW-1], prv_l};
  assign db_s = {t_q[TW-1], t_q} - {cur_l[TW-1], cur_l};
  assign da   = da_s[TW] ? -da_s : da_s;
  assign db   = db_s[TW] ? -db_s : db_s;

  // --------------------------------------------------------------------------
  // Multiply/divide unit: round(d1*mag/dl)
  // --------------------------------------------------------------------------
  md_stat_t      md_stat;
  logic          md_start;
  logic [TW-1:0] md_quot, md_rem;
  logic [TW:0]   rem_x2;
  logic [TW-1:0] q_rnd;

  assign md_start = state_q == ST_SLOPE && !(d1_q != '0 && slope_bad);

  smtc_muldiv #(
    .TW(TW)
  ) u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (md_start),
    .mplier_i  (d1_q),
    .mcand_i   (mag_q),
    .divisor_i (dl_q),
    .stat_o    (md_stat),
    .quot_o    (md_quot),
    .rem_o     (md_rem)
  );

  // halves round away from zero on the magnitude
  assign rem_x2 = {md_rem, 1'b0};
  assign q_rnd  = md_quot + ((rem_x2 >= {1'b0, dl_q}) ? TW'(1) : TW'(0));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic       put_go;
  assign put_go = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      scan_k_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_PUT;
            unique case (action_e'(action_i))
              ACT_APPEND: begin
                if (!table_full) begin
                  cnt_q <= cnt_q + IW'(1);
                end
              end
              ACT_CLEAR: cnt_q <= '0;
              ACT_CONVERT: begin
                if (sync_mode_q != MODE_PASS && cnt_q != '0) begin
                  if (sync_mode_q == MODE_INTERP && cnt_q > IW'(1)) begin
                    if (hint_index_i != '0 && hint_index_i < cnt_m1) begin
                      state_q <= ST_HA;
                    end else begin
                      state_q <= ST_SCAN;
                    end
                  end else if (sync_mode_q == MODE_RIGHT) begin
                    state_q <= (hint_index_i < cnt_q) ? ST_HA : ST_SCAN;
                  end else begin
                    state_q <= ST_EA;
                  end
                end
              end
              default: ;
            endcase
            scan_k_q <= '0;
            rd_vld_q <= 1'b0;
          end
        end
        ST_HA: state_q <= ST_HB;
        ST_HB: state_q <= ST_HC;
        ST_HC: begin
          if (ev_hit) begin
            state_q <= (sync_mode_q == MODE_INTERP) ? ST_SLOPE : ST_PUT;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_k_q < cnt_q) begin
            scan_k_q <= scan_k_q + IW'(1);
            rd_vld_q <= 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (rd_vld_q) begin
            if (ev_hit && !ev_skip) begin
              state_q  <= (sync_mode_q == MODE_INTERP) ? ST_SLOPE : ST_PUT;
              rd_vld_q <= 1'b0;
            end else if (rd_k_q == cnt_m1) begin
              state_q  <= ST_EA;
              rd_vld_q <= 1'b0;
            end
          end
        end
        ST_SLOPE: state_q <= md_start ? ST_MD : ST_PUT;
        ST_MD: begin
          if (md_stat.done) begin
            state_q <= ST_RND;
          end
        end
        ST_RND: state_q <= ST_PUT;
        ST_EA:  state_q <= ST_EB;
        ST_EB:  state_q <= ST_EC;
        ST_EC:  state_q <= ST_PUT;
        ST_PUT: begin
          if (put_go) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          t_q        <= local_time_i;
          hint_q     <= hint_index_i;
          use_hint_q <= hint_index_i != '0 && hint_index_i < cnt_m1;
          res_g_q    <= '0;
          res_idx_q  <= '0;
          res_st_q   <= STAT_OK;
          unique case (action_e'(action_i))
            ACT_APPEND: begin
              res_idx_q <= table_full ? cnt_q : cnt_q + IW'(1);
              res_st_q  <= table_full ? STAT_FULL : STAT_OK;
            end
            ACT_CONVERT: begin
              if (sync_mode_q == MODE_PASS) begin
                res_g_q   <= local_time_i;
                res_idx_q <= hint_index_i;
              end else if (cnt_q == '0) begin
                res_st_q <= STAT_NOSYNC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_HB: prev_q <= rd_data_q;
      ST_SCAN: begin
        if (scan_k_q < cnt_q) begin
          rd_k_q <= scan_k_q;
        end
        if (rd_vld_q) begin
          prev_q <= rd_data_q;
        end
      end
      ST_EB: prev_q <= rd_data_q;
      default: ;
    endcase

    // capture on a hit in the hint pair or the scan
    if ((state_q == ST_HC && ev_hit) || (state_q == ST_SCAN && rd_vld_q && ev_hit && !ev_skip)) begin
      res_idx_q <= ev_k;
      res_st_q  <= STAT_OK;
      res_g_q   <= right_g;
      dl_q      <= seg_dl[TW-1:0];
      d1_q      <= seg_d1[TW-1:0];
      mag_q     <= seg_mag[TW-1:0];
      neg_q     <= seg_dg[TW];
      g1_q      <= prv_g;
    end

    if (state_q == ST_SLOPE && !md_start) begin
      res_g_q  <= '0;
      res_st_q <= STAT_SLOPE;
    end

    if (state_q == ST_RND) begin
      res_g_q <= neg_q ? g1_q - q_rnd : g1_q + q_rnd;
    end

    if (state_q == ST_EC) begin
      res_st_q <= STAT_OK;
      if (da < db) begin
        res_g_q   <= prv_g + t_q - prv_l;
        res_idx_q <= '0;
      end else begin
        res_g_q   <= cur_g + t_q - cur_l;
        res_idx_q <= cnt_q;
      end
    end

    if (state_q == ST_PUT && put_go) begin
      out_g_q   <= res_g_q;
      out_idx_q <= res_idx_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign global_time_o = out_g_q;
  assign sync_index_o  = out_idx_q;
  assign status_o      = out_st_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  `SMTC_ASSERT(a_cnt_bound, cnt_q <= IW'(SYNC_DEPTH), "sync count beyond table depth")
  `SMTC_ASSERT(a_md_start_idle, md_start |-> !md_stat.busy, "muldiv started while busy")
  `SMTC_ASSERT(a_nosync_zero, (out_valid_o && status_o == STAT_NOSYNC) |-> (global_time_o == '0), "no-sync result not zero")
  `SMTC_ASSERT(a_md_wait, (state_q == ST_MD) |-> md_stat.busy || md_stat.done, "waiting on idle muldiv")

endmodule
